[hw/rtl/cbf_pkg.sv]
// Shared types and constants for the cubic Bezier flattener.
// Holds the request and vertex payload structs; no dependencies.
`default_nettype none

package cbf_pkg;

	localparam int unsigned COORD_W = 32;
	localparam int unsigned TOL_W   = 31;
	localparam int unsigned ACC_W   = 36;

	localparam logic [TOL_W-1:0] TOL_RESET = 31'd32768;

	// one curve segment, signed Q11.21 coordinates
	typedef struct packed {
		logic signed [COORD_W-1:0] start_x;
		logic signed [COORD_W-1:0] start_y;
		logic signed [COORD_W-1:0] ctrl1_x;
		logic signed [COORD_W-1:0] ctrl1_y;
		logic signed [COORD_W-1:0] ctrl2_x;
		logic signed [COORD_W-1:0] ctrl2_y;
		logic signed [COORD_W-1:0] end_x;
		logic signed [COORD_W-1:0] end_y;
	} in_item_t;

	// one polyline vertex
	typedef struct packed {
		logic signed [COORD_W-1:0] vertex_x;
		logic signed [COORD_W-1:0] vertex_y;
		logic                      last_vertex;
	} out_item_t;

endpackage

`default_nettype wire

[hw/rtl/cubic_bezier_flattener.sv]
// Cubic Bezier flattener: adaptive de Casteljau subdivision under a small sequencer.
// Uses cbf_pkg for payload types and constants.
// Sequence: an accepted request loads the start vertex from ST_START; each piece then runs
// the flatness test states (x, y, decide) and each split the states S1, S2, S3 on the shared
// midpoint unit, until every piece is flat or at the depth cap (MAX_DEPTH, 5 by default).
// Throughput: one curve at a time; the request port is ready only while idle.
// Reset: sequencer idle, stack empty, output empty, tolerance 32768 (1/64).
`default_nettype none

module cubic_bezier_flattener #(
	parameter int MAX_DEPTH = 5
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire logic [30:0]       cfg_wr_data,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire cbf_pkg::in_item_t in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output cbf_pkg::out_item_t     out_data
);
	import cbf_pkg::*;

	localparam int SW = $clog2(MAX_DEPTH + 1);
	localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_START = 3'd1;
	localparam logic [2:0] ST_TX    = 3'd2;
	localparam logic [2:0] ST_TY    = 3'd3;
	localparam logic [2:0] ST_DEC   = 3'd4;
	localparam logic [2:0] ST_S1    = 3'd5;
	localparam logic [2:0] ST_S2    = 3'd6;
	localparam logic [2:0] ST_S3    = 3'd7;

	// floor((a + b) / 2) without overflow
	function automatic logic signed [COORD_W-1:0] mid(
		input logic signed [COORD_W-1:0] a,
		input logic signed [COORD_W-1:0] b
	);
		logic [COORD_W:0] s;
		s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
		return s[COORD_W:1];
	endfunction

	// |a + c - 2b|, exact
	function automatic logic [COORD_W+1:0] sdiff_mag(
		input logic signed [COORD_W-1:0] a,
		input logic signed [COORD_W-1:0] b,
		input logic signed [COORD_W-1:0] c
	);
		logic [COORD_W+2:0] d;
		logic [COORD_W+2:0] n;
		d = {{3{a[COORD_W-1]}}, a} + {{3{c[COORD_W-1]}}, c}
			- {{2{b[COORD_W-1]}}, b, 1'b0};
		n = -d;
		return d[COORD_W+2] ? n[COORD_W+1:0] : d[COORD_W+1:0];
	endfunction

	logic [2:0]              state_q;
	logic [SW-1:0]           sp_q;
	logic [SW-1:0]           depth_q;
	logic [TOL_W-1:0]        tol_q;
	logic [ACC_W-1:0]        acc_q;
	logic                    out_valid_q;
	out_item_t               out_data_q;

	logic signed [COORD_W-1:0] px_q [4];
	logic signed [COORD_W-1:0] py_q [4];
	logic signed [COORD_W-1:0] wx_q [3];
	logic signed [COORD_W-1:0] wy_q [3];
	logic signed [COORD_W-1:0] rx1_q, ry1_q, rx2_q, ry2_q;

	logic signed [COORD_W-1:0] stk_x_q [MAX_DEPTH][4];
	logic signed [COORD_W-1:0] stk_y_q [MAX_DEPTH][4];
	logic [SW-1:0]             stk_lvl_q [MAX_DEPTH];

	logic                    accept;
	logic                    out_free;
	logic                    flat;
	logic                    emit_mid;
	logic                    load_out;
	logic                    stack_empty;
	logic [SW-1:0]           sp_dec;
	logic [IW-1:0]           push_idx;
	logic [IW-1:0]           top_idx;
	logic [SW-1:0]           depth_inc;
	logic signed [COORD_W-1:0] vx [4];
	logic signed [COORD_W-1:0] vy [4];
	logic signed [COORD_W-1:0] mx [3];
	logic signed [COORD_W-1:0] my [3];
	logic signed [COORD_W-1:0] dv [4];
	logic [COORD_W+2:0]      mag_sum;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_free  = !out_valid_q || out_ready;

	assign stack_empty = (sp_q == '0);
	assign sp_dec      = sp_q - SW'(1);
	assign push_idx    = sp_q[IW-1:0];
	assign top_idx     = sp_dec[IW-1:0];
	assign depth_inc   = depth_q + SW'(1);

	// flat test result; a piece at the depth cap is flat without a test
	assign flat     = (depth_q == SW'(MAX_DEPTH)) || (acc_q <= {{(ACC_W-TOL_W){1'b0}}, tol_q});
	assign emit_mid = (state_q == ST_DEC) && flat && out_free;
	assign load_out = ((state_q == ST_START) && out_free) || emit_mid;

	// shared midpoint unit: adjacent-pair midpoints of the piece or of the split triangle
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			vx[k] = px_q[k];
			vy[k] = py_q[k];
		end
		if (state_q == ST_S2 || state_q == ST_S3) begin
			for (int k = 0; k < 3; k++) begin
				vx[k] = wx_q[k];
				vy[k] = wy_q[k];
			end
			vx[3] = wx_q[2];
			vy[3] = wy_q[2];
		end
		for (int k = 0; k < 3; k++) begin
			mx[k] = mid(vx[k], vx[k+1]);
			my[k] = mid(vy[k], vy[k+1]);
		end
	end

	// shared second-difference unit, one axis per cycle
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			dv[k] = (state_q == ST_TY) ? py_q[k] : px_q[k];
		end
		mag_sum = {1'b0, sdiff_mag(dv[0], dv[1], dv[2])}
			+ {1'b0, sdiff_mag(dv[1], dv[2], dv[3])};
	end

	// sequencer, stack pointer, output valid and tolerance register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sp_q        <= '0;
			out_valid_q <= 1'b0;
			tol_q       <= TOL_RESET;
		end else begin
			if (cfg_wr_en) begin
				tol_q <= cfg_wr_data;
			end
			// drop the vertex once taken, unless a new one is loaded
			if (out_valid_q && out_ready && !load_out) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						sp_q    <= '0;
						state_q <= ST_START;
					end
				end
				ST_START: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_TX;
					end
				end
				ST_TX: begin
					state_q <= ST_TY;
				end
				ST_TY: begin
					state_q <= ST_DEC;
				end
				ST_DEC: begin
					if (!flat) begin
						state_q <= ST_S1;
					end else if (out_free) begin
						out_valid_q <= 1'b1;
						if (stack_empty) begin
							state_q <= ST_IDLE;
						end else begin
							sp_q    <= sp_dec;
							state_q <= ST_TX;
						end
					end
				end
				ST_S1: begin
					state_q <= ST_S2;
				end
				ST_S2: begin
					state_q <= ST_S3;
				end
				ST_S3: begin
					sp_q    <= sp_q + SW'(1);
					state_q <= ST_TX;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath: current piece, split triangle, stack and output vertex
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					px_q[0] <= in_data.start_x;
					py_q[0] <= in_data.start_y;
					px_q[1] <= in_data.ctrl1_x;
					py_q[1] <= in_data.ctrl1_y;
					px_q[2] <= in_data.ctrl2_x;
					py_q[2] <= in_data.ctrl2_y;
					px_q[3] <= in_data.end_x;
					py_q[3] <= in_data.end_y;
					depth_q <= '0;
				end
			end
			ST_START: begin
				if (out_free) begin
					out_data_q.vertex_x    <= px_q[0];
					out_data_q.vertex_y    <= py_q[0];
					out_data_q.last_vertex <= 1'b0;
				end
			end
			ST_TX: begin
				acc_q <= {1'b0, mag_sum};
			end
			ST_TY: begin
				acc_q <= acc_q + {1'b0, mag_sum};
			end
			ST_DEC: begin
				// emit the midpoint of points 1 and 2, then pop the next waiting right half
				if (emit_mid) begin
					out_data_q.vertex_x    <= mx[1];
					out_data_q.vertex_y    <= my[1];
					out_data_q.last_vertex <= stack_empty;
					if (!stack_empty) begin
						for (int k = 0; k < 4; k++) begin
							px_q[k] <= stk_x_q[top_idx][k];
							py_q[k] <= stk_y_q[top_idx][k];
						end
						depth_q <= stk_lvl_q[top_idx];
					end
				end
			end
			ST_S1: begin
				for (int k = 0; k < 3; k++) begin
					wx_q[k] <= mx[k];
					wy_q[k] <= my[k];
				end
				px_q[1] <= mx[0];
				py_q[1] <= my[0];
				rx2_q   <= mx[2];
				ry2_q   <= my[2];
			end
			ST_S2: begin
				wx_q[0] <= mx[0];
				wy_q[0] <= my[0];
				wx_q[1] <= mx[1];
				wy_q[1] <= my[1];
				px_q[2] <= mx[0];
				py_q[2] <= my[0];
				rx1_q   <= mx[1];
				ry1_q   <= my[1];
			end
			ST_S3: begin
				// push the right half, continue on the left half
				stk_x_q[push_idx][0] <= mx[0];
				stk_y_q[push_idx][0] <= my[0];
				stk_x_q[push_idx][1] <= rx1_q;
				stk_y_q[push_idx][1] <= ry1_q;
				stk_x_q[push_idx][2] <= rx2_q;
				stk_y_q[push_idx][2] <= ry2_q;
				stk_x_q[push_idx][3] <= px_q[3];
				stk_y_q[push_idx][3] <= py_q[3];
				stk_lvl_q[push_idx]  <= depth_inc;
				px_q[3] <= mx[0];
				py_q[3] <= my[0];
				depth_q <= depth_inc;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire
